// ----- rtl/stereo_mid_side_gain_smoother_top_macros.svh -----
// Assertion macros for the stereo mid/side gain smoother.
// Included by the top level; expects clk and arst_n in scope.
`ifndef STEREO_MID_SIDE_GAIN_SMOOTHER_TOP_MACROS_SVH
`define STEREO_MID_SIDE_GAIN_SMOOTHER_TOP_MACROS_SVH
`ifndef SYNTH
`define SMGS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SMGS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SMGS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SMGS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/smgs_pkg.sv -----
// Shared constants and types of the stereo mid/side gain smoother.
// No dependencies; compile first.
package smgs_pkg;

	localparam int BETA_BITS  = 25;
	localparam int LEVEL_BITS = 24;
	localparam int GOAL_BITS  = 24;
	localparam int MANT_BITS  = 23;
	localparam int EXP_BITS   = 7;
	localparam int GAIN_BITS  = 24;
	localparam int CLIP_BITS  = 2;
	localparam int PADDR_BITS = 5;
	localparam int PDATA_BITS = 32;

	// Rescaling shifts (right shift applied to each product when it is rounded)
	localparam int SH_LEVEL = 24;
	localparam int SH_MIX   = 21;
	localparam int SH_FADER = 23;
	localparam int SH_MANT  = 22;
	localparam int SH_GAIN  = 20;

	localparam logic [BETA_BITS-1:0]  BETA_ONE   = 25'h100_0000;
	localparam logic [BETA_BITS-1:0]  BETA_RST   = 25'h100_0000;
	localparam logic [GOAL_BITS-1:0]  GOAL_RST   = 24'h80_0000;
	localparam logic [MANT_BITS-1:0]  MANT_RST   = 23'h40_0000;
	localparam logic [EXP_BITS-1:0]   EXP_RST    = 7'h00;
	localparam logic [GAIN_BITS-1:0]  GAIN_RST   = 24'h10_0000;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX  = 24'hFF_FFFF;

	typedef enum logic [2:0] {
		CFG_BETA  = 3'd0,
		CFG_GOAL  = 3'd1,
		CFG_MANT  = 3'd2,
		CFG_EXP   = 3'd3,
		CFG_LEFT  = 3'd4,
		CFG_RIGHT = 3'd5,
		CFG_MID   = 3'd6,
		CFG_SIDE  = 3'd7
	} cfg_idx_t;

endpackage

// ----- rtl/smgs_in_if.sv -----
// Input stream channel: one stereo sample pair per transfer.
// No dependencies.
interface smgs_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ----- rtl/smgs_out_if.sv -----
// Output stream channel: processed stereo pair and clip flags per transfer.
// Depends on smgs_pkg.
interface smgs_out_if #(parameter int SAMPLE_BITS = 24);
	import smgs_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic [CLIP_BITS-1:0]          clip_flags;

	modport source (output valid, output left_out, output right_out, output clip_flags,
		input ready);
	modport sink   (input valid, input left_out, input right_out, input clip_flags,
		output ready);
endinterface

// ----- rtl/stereo_mid_side_gain_smoother_top.sv -----
// Stereo mid/side gain smoother, top level. Uses smgs_pkg, smgs_in_if,
// smgs_out_if and stereo_mid_side_gain_smoother_top_macros.svh.
//
// One stereo pair enters per input transfer. The fader level first steps
// toward its goal by beta*(goal-level), then the pair is split into mid and
// side, each weighted, recombined into left and right, and scaled by the
// level, the pre-gain mantissa and the channel gain, each product rounded
// half up. The power-of-two exponent is applied last with saturation to
// SAMPLE_BITS; clip_flags bit 0 marks left saturation, bit 1 right. All nine
// products run through one signed multiplier with a rounding stage behind
// it, sequenced by a step counter. The input is not ready while an item
// is in flight, and the final step holds until the output register is
// free; a finished result waits in the output register, and the next
// pair is taken meanwhile. Registers are written over the APB port at
// byte address 4*index and should be changed only while the block is
// idle.
`include "stereo_mid_side_gain_smoother_top_macros.svh"

module stereo_mid_side_gain_smoother_top #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [smgs_pkg::PADDR_BITS-1:0]  paddr,
	input  logic [smgs_pkg::PDATA_BITS-1:0]  pwdata,
	output logic [smgs_pkg::PDATA_BITS-1:0]  prdata,
	output logic                             pready,
	smgs_in_if.sink                          sample_in,
	smgs_out_if.source                       sample_out
);
	import smgs_pkg::*;

	localparam int S      = SAMPLE_BITS;
	localparam int SUM_W  = S + 1;
	localparam int MID_W  = S + 4;
	localparam int MIX_W  = S + 5;
	localparam int ACC_W  = S + 11;
	localparam int RS_W   = ACC_W + 1;
	localparam int DIFF_W = LEVEL_BITS + 2;
	localparam int LSUM_W = LEVEL_BITS + 3;
	localparam int MA_W   = (S + 7 > DIFF_W) ? S + 7 : DIFF_W;
	localparam int MB_W   = BETA_BITS;
	localparam int PROD_W = MA_W + MB_W + 1;

	localparam logic signed [RS_W-1:0] SAT_HI  = RS_W'((64'(1) << (S - 1)) - 64'(1));
	localparam logic signed [RS_W-1:0] SAT_LO  = -SAT_HI - RS_W'(1);
	localparam logic        [RS_W-1:0] LO_MAG  = RS_W'(64'(1) << (S - 1));
	localparam logic        [6:0]      SHR_MAX = 7'(ACC_W);

	localparam logic [3:0] STEP_LEVEL = 4'd0;
	localparam logic [3:0] STEP_MID   = 4'd1;
	localparam logic [3:0] STEP_SIDE  = 4'd2;
	localparam logic [3:0] STEP_L1    = 4'd4;
	localparam logic [3:0] STEP_R1    = 4'd5;
	localparam logic [3:0] STEP_L2    = 4'd6;
	localparam logic [3:0] STEP_R2    = 4'd7;
	localparam logic [3:0] STEP_L3    = 4'd8;
	localparam logic [3:0] STEP_R3    = 4'd9;
	localparam logic [3:0] STEP_EXP_L = 4'd10;
	localparam logic [3:0] STEP_EXP_R = 4'd11;
	localparam logic [3:0] STEP_LAST  = 4'd12;

	typedef enum logic {ST_IDLE, ST_BUSY} state_t;

	typedef enum logic [3:0] {
		OP_LEVEL, OP_MID, OP_SIDE, OP_L1, OP_R1, OP_L2, OP_R2, OP_L3, OP_R3
	} mul_op_t;

	// Configuration registers
	logic        [BETA_BITS-1:0] beta_q;
	logic        [GOAL_BITS-1:0] goal_q;
	logic        [MANT_BITS-1:0] mant_q;
	logic signed [EXP_BITS-1:0]  exp_q;
	logic        [GAIN_BITS-1:0] left_gain_q;
	logic        [GAIN_BITS-1:0] right_gain_q;
	logic        [GAIN_BITS-1:0] mid_gain_q;
	logic        [GAIN_BITS-1:0] side_gain_q;
	logic                        cfg_wr;

	// Control and state
	state_t                  state_q;
	logic [3:0]              step_q;
	logic [LEVEL_BITS-1:0]   level_q;
	logic                    prod_vld_s1;
	logic                    out_vld_q;
	logic signed [S-1:0]     out_left_q;
	logic signed [S-1:0]     out_right_q;
	logic [CLIP_BITS-1:0]    out_clip_q;

	// Datapath registers
	logic signed [S-1:0]      l_q;
	logic signed [S-1:0]      r_q;
	logic signed [MID_W-1:0]  mid_q;
	logic signed [MID_W-1:0]  side_q;
	logic signed [ACC_W-1:0]  lx_q;
	logic signed [ACC_W-1:0]  rx_q;
	logic signed [PROD_W-1:0] prod_s1;
	mul_op_t                  prod_op_s1;
	logic signed [S-1:0]      res_l_q;
	logic signed [S-1:0]      res_r_q;
	logic                     clip_l_q;
	logic                     clip_r_q;

	// Combinational datapath
	logic                     in_xfer;
	logic                     out_load;
	logic                     issue_vld;
	mul_op_t                  issue_op;
	logic [BETA_BITS-1:0]     beta_eff;
	logic signed [DIFF_W-1:0] level_diff;
	logic signed [SUM_W-1:0]  sum_lr;
	logic signed [SUM_W-1:0]  dif_lr;
	logic signed [MIX_W-1:0]  mix_l;
	logic signed [MIX_W-1:0]  mix_r;
	logic signed [MA_W-1:0]   mul_a;
	logic        [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod_next;
	logic [4:0]               rnd_k;
	logic signed [PROD_W-1:0] rnd_sum;
	logic signed [PROD_W-1:0] rnd_val;
	logic signed [LSUM_W-1:0] lvl_sum;
	logic [LEVEL_BITS-1:0]    lvl_next;
	logic signed [ACC_W-1:0]  ex_x;
	logic signed [RS_W-1:0]   ex_xe;
	logic [6:0]               ex_sh;
	logic [RS_W-1:0]          ex_pos_lim;
	logic [RS_W-1:0]          ex_neg_lim;
	logic [RS_W-1:0]          ex_rbit;
	logic signed [RS_W-1:0]   ex_rsum;
	logic signed [RS_W-1:0]   ex_rsh;
	logic signed [S-1:0]      ex_val;
	logic                     ex_clip;

	// ---------------------------------------------------------------
	// Configuration port: writes land on the access cycle, reads are
	// straight from the registers.
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q       <= BETA_RST;
			goal_q       <= GOAL_RST;
			mant_q       <= MANT_RST;
			exp_q        <= EXP_RST;
			left_gain_q  <= GAIN_RST;
			right_gain_q <= GAIN_RST;
			mid_gain_q   <= GAIN_RST;
			side_gain_q  <= GAIN_RST;
		end else if (cfg_wr) begin
			case (cfg_idx_t'(paddr[4:2]))
				CFG_BETA:  beta_q       <= pwdata[BETA_BITS-1:0];
				CFG_GOAL:  goal_q       <= pwdata[GOAL_BITS-1:0];
				CFG_MANT:  mant_q       <= pwdata[MANT_BITS-1:0];
				CFG_EXP:   exp_q        <= pwdata[EXP_BITS-1:0];
				CFG_LEFT:  left_gain_q  <= pwdata[GAIN_BITS-1:0];
				CFG_RIGHT: right_gain_q <= pwdata[GAIN_BITS-1:0];
				CFG_MID:   mid_gain_q   <= pwdata[GAIN_BITS-1:0];
				CFG_SIDE:  side_gain_q  <= pwdata[GAIN_BITS-1:0];
				default:   beta_q       <= beta_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx_t'(paddr[4:2]))
			CFG_BETA:  prdata = PDATA_BITS'(beta_q);
			CFG_GOAL:  prdata = PDATA_BITS'(goal_q);
			CFG_MANT:  prdata = PDATA_BITS'(mant_q);
			CFG_EXP:   prdata = PDATA_BITS'($unsigned(exp_q));
			CFG_LEFT:  prdata = PDATA_BITS'(left_gain_q);
			CFG_RIGHT: prdata = PDATA_BITS'(right_gain_q);
			CFG_MID:   prdata = PDATA_BITS'(mid_gain_q);
			CFG_SIDE:  prdata = PDATA_BITS'(side_gain_q);
			default:   prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Handshakes
	// ---------------------------------------------------------------
	assign sample_in.ready       = (state_q == ST_IDLE);
	assign in_xfer               = sample_in.valid & sample_in.ready;
	// Final step loads the output register once it is free or being drained
	assign out_load              = (state_q == ST_BUSY) && (step_q == STEP_LAST) &&
	                               (!out_vld_q || sample_out.ready);
	assign sample_out.valid      = out_vld_q;
	assign sample_out.left_out   = out_left_q;
	assign sample_out.right_out  = out_right_q;
	assign sample_out.clip_flags = out_clip_q;

	// ---------------------------------------------------------------
	// Issue schedule: one product per step into the shared multiplier.
	// The idle step after SIDE lets the side term settle before the mixes.
	// ---------------------------------------------------------------
	always_comb begin
		issue_vld = (state_q == ST_BUSY);
		case (step_q)
			STEP_LEVEL: issue_op = OP_LEVEL;
			STEP_MID:   issue_op = OP_MID;
			STEP_SIDE:  issue_op = OP_SIDE;
			STEP_L1:    issue_op = OP_L1;
			STEP_R1:    issue_op = OP_R1;
			STEP_L2:    issue_op = OP_L2;
			STEP_R2:    issue_op = OP_R2;
			STEP_L3:    issue_op = OP_L3;
			STEP_R3:    issue_op = OP_R3;
			default: begin
				issue_op  = OP_LEVEL;
				issue_vld = 1'b0;
			end
		endcase
	end

	// Beta above one acts as one
	assign beta_eff   = (beta_q > BETA_ONE) ? BETA_ONE : beta_q;
	assign level_diff = $signed({2'b00, goal_q}) - $signed({2'b00, level_q});
	assign sum_lr     = SUM_W'(l_q) + SUM_W'(r_q);
	assign dif_lr     = SUM_W'(l_q) - SUM_W'(r_q);
	assign mix_l      = MIX_W'(mid_q) + MIX_W'(side_q);
	assign mix_r      = MIX_W'(mid_q) - MIX_W'(side_q);

	// Operand select for the shared multiplier
	always_comb begin
		case (issue_op)
			OP_LEVEL: begin
				mul_a = MA_W'(level_diff);
				mul_b = beta_eff;
			end
			OP_MID: begin
				mul_a = MA_W'(sum_lr);
				mul_b = MB_W'(mid_gain_q);
			end
			OP_SIDE: begin
				mul_a = MA_W'(dif_lr);
				mul_b = MB_W'(side_gain_q);
			end
			OP_L1: begin
				mul_a = MA_W'(mix_l);
				mul_b = MB_W'(level_q);
			end
			OP_R1: begin
				mul_a = MA_W'(mix_r);
				mul_b = MB_W'(level_q);
			end
			OP_L2: begin
				mul_a = $signed(lx_q[MA_W-1:0]);
				mul_b = MB_W'(mant_q);
			end
			OP_R2: begin
				mul_a = $signed(rx_q[MA_W-1:0]);
				mul_b = MB_W'(mant_q);
			end
			OP_L3: begin
				mul_a = $signed(lx_q[MA_W-1:0]);
				mul_b = MB_W'(left_gain_q);
			end
			OP_R3: begin
				mul_a = $signed(rx_q[MA_W-1:0]);
				mul_b = MB_W'(right_gain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_next = mul_a * $signed({1'b0, mul_b});

	// ---------------------------------------------------------------
	// Rounding stage: round half up of the registered product
	// ---------------------------------------------------------------
	always_comb begin
		case (prod_op_s1)
			OP_LEVEL:        rnd_k = 5'(SH_LEVEL);
			OP_MID, OP_SIDE: rnd_k = 5'(SH_MIX);
			OP_L1, OP_R1:    rnd_k = 5'(SH_FADER);
			OP_L2, OP_R2:    rnd_k = 5'(SH_MANT);
			OP_L3, OP_R3:    rnd_k = 5'(SH_GAIN);
			default:         rnd_k = 5'(SH_GAIN);
		endcase
		rnd_sum = prod_s1 + $signed(PROD_W'(1) << (rnd_k - 5'd1));
		rnd_val = rnd_sum >>> rnd_k;
	end

	// New fader level, clamped to the level range
	always_comb begin
		lvl_sum = $signed({3'b000, level_q}) + $signed(rnd_val[LSUM_W-1:0]);
		if (lvl_sum < 0) begin
			lvl_next = '0;
		end else if (lvl_sum > $signed({3'b000, LEVEL_MAX})) begin
			lvl_next = LEVEL_MAX;
		end else begin
			lvl_next = lvl_sum[LEVEL_BITS-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Exponent unit: shift by 2^e with saturation, shared by both channels
	// ---------------------------------------------------------------
	always_comb begin
		ex_x       = (step_q == STEP_EXP_R) ? rx_q : lx_q;
		ex_xe      = RS_W'(ex_x);
		ex_sh      = '0;
		ex_pos_lim = '0;
		ex_neg_lim = '0;
		ex_rbit    = '0;
		ex_rsum    = '0;
		ex_rsh     = '0;
		ex_clip    = 1'b0;
		ex_val     = '0;
		if (!exp_q[EXP_BITS-1]) begin
			ex_sh      = $unsigned(exp_q);
			ex_pos_lim = $unsigned(SAT_HI) >> ex_sh;
			ex_neg_lim = LO_MAG >> ex_sh;
			if (ex_xe >= 0) begin
				if (ex_xe > $signed(ex_pos_lim)) begin
					ex_clip = 1'b1;
					ex_val  = SAT_HI[S-1:0];
				end else begin
					ex_val = ex_x[S-1:0] << ex_sh;
				end
			end else begin
				if (ex_xe < -$signed(ex_neg_lim)) begin
					ex_clip = 1'b1;
					ex_val  = SAT_LO[S-1:0];
				end else begin
					ex_val = ex_x[S-1:0] << ex_sh;
				end
			end
		end else begin
			// Right shifts past the accumulator width all round to zero
			ex_sh = $unsigned(-exp_q);
			if (ex_sh > SHR_MAX) begin
				ex_sh = SHR_MAX;
			end
			ex_rbit = RS_W'(1) << (ex_sh - 7'd1);
			ex_rsum = ex_xe + $signed(ex_rbit);
			ex_rsh  = ex_rsum >>> ex_sh;
			if (ex_rsh > SAT_HI) begin
				ex_clip = 1'b1;
				ex_val  = SAT_HI[S-1:0];
			end else if (ex_rsh < SAT_LO) begin
				ex_clip = 1'b1;
				ex_val  = SAT_LO[S-1:0];
			end else begin
				ex_val = ex_rsh[S-1:0];
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequencer, fader level and output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			level_q     <= '0;
			prod_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			prod_vld_s1 <= issue_vld;
			if (prod_vld_s1 && (prod_op_s1 == OP_LEVEL)) begin
				level_q <= lvl_next;
			end
			// Drop the result once it is taken and no new one replaces it
			if (sample_out.ready && !out_load) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_BUSY;
						step_q  <= '0;
					end
				end
				ST_BUSY: begin
					if (step_q == STEP_LAST) begin
						// Hold here until the previous result is drained
						if (out_load) begin
							state_q     <= ST_IDLE;
							out_vld_q   <= 1'b1;
							out_left_q  <= res_l_q;
							out_right_q <= res_r_q;
							out_clip_q  <= {clip_r_q, clip_l_q};
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers; no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			l_q <= sample_in.left_in;
			r_q <= sample_in.right_in;
		end
		prod_s1    <= prod_next;
		prod_op_s1 <= issue_op;
		if (prod_vld_s1) begin
			case (prod_op_s1)
				OP_MID:                      mid_q  <= rnd_val[MID_W-1:0];
				OP_SIDE:                     side_q <= rnd_val[MID_W-1:0];
				OP_L1, OP_L2, OP_L3:         lx_q   <= rnd_val[ACC_W-1:0];
				OP_R1, OP_R2, OP_R3:         rx_q   <= rnd_val[ACC_W-1:0];
				default:                     mid_q  <= mid_q;
			endcase
		end
		if (state_q == ST_BUSY && step_q == STEP_EXP_L) begin
			res_l_q  <= ex_val;
			clip_l_q <= ex_clip;
		end
		if (state_q == ST_BUSY && step_q == STEP_EXP_R) begin
			res_r_q  <= ex_val;
			clip_r_q <= ex_clip;
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`SMGS_ASSERT_NEXT(a_accept_starts_busy, in_xfer, !sample_in.ready && step_q == STEP_LEVEL, "input transfer did not start the sequence")
	`SMGS_ASSERT_IMPLY(a_prod_only_busy, prod_vld_s1, state_q == ST_BUSY, "product in flight while idle")
	`SMGS_ASSERT_NEXT(a_level_hold, !(prod_vld_s1 && prod_op_s1 == OP_LEVEL), $stable(level_q), "fader level changed outside its update")
	`SMGS_ASSERT_IMPLY(a_out_from_last, $rose(out_vld_q), $past(state_q == ST_BUSY && step_q == STEP_LAST), "result raised outside the final step")

endmodule
